>>> hdl/jdzc_pkg.sv
// shared widths, codes and reset values of the joystick dead-zone cursor
package jdzc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int POS_W    = 10;
    localparam int SPEED_W  = 11;
    localparam int CFG_IDX_W = 3;

    // offset divided by 16 is a right shift by this amount
    localparam int STEP_SHIFT = 4;
    localparam int STEP_W     = SAMPLE_W - STEP_SHIFT;

    // input operations
    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_REST_X    = 3'd0,
        REG_REST_Y    = 3'd1,
        REG_DEAD_ZONE = 3'd2,
        REG_LIMIT_X   = 3'd3,
        REG_LIMIT_Y   = 3'd4
    } reg_idx_t;

    // reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] REST_X_RST    = 10'd512;
    localparam logic [SAMPLE_W-1:0] REST_Y_RST    = 10'd512;
    localparam logic [SAMPLE_W-1:0] DEAD_ZONE_RST = 10'd16;
    localparam logic [POS_W-1:0]    LIMIT_X_RST   = 10'd799;
    localparam logic [POS_W-1:0]    LIMIT_Y_RST   = 10'd479;

    // axis select codes
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

endpackage

>>> hdl/joystick_dead_zone_cursor.sv
// joystick dead-zone cursor: center, dead zone, velocity and clamped cursor per axis sample
//
// Each sample item belongs to the axis that the block selects itself, starting
// with X and alternating after every sample; a read item only clears the motion
// flag. The block takes one item per clock cycle while in_stall is low and gives
// one result item per input item: the item is captured in an input register,
// the offset, dead-zone, step and clamp logic works on the held item and
// writes the cursor state and the result register together. The result
// register holds a stalled result while the input register keeps accepting
// until both are full. Configuration writes are always ready and take effect
// for items processed after the write.
module joystick_dead_zone_cursor
    import jdzc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input item channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic [SAMPLE_W-1:0]    sample,
    // result item channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [POS_W-1:0]       cursor_x,
    output logic [POS_W-1:0]       cursor_y,
    output logic signed [SPEED_W-1:0] speed_x,
    output logic signed [SPEED_W-1:0] speed_y,
    output logic                   motion_pending,
    output logic                   next_axis,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SAMPLE_W-1:0]    cfg_data
);

    // configuration registers
    logic [SAMPLE_W-1:0] rest_x_reg;
    logic [SAMPLE_W-1:0] rest_y_reg;
    logic [SAMPLE_W-1:0] dead_zone_reg;
    logic [POS_W-1:0]    limit_x_reg;
    logic [POS_W-1:0]    limit_y_reg;

    // input stage
    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;

    // cursor state
    logic [POS_W-1:0]          pos_x_reg, pos_x_next;
    logic [POS_W-1:0]          pos_y_reg, pos_y_next;
    logic signed [SPEED_W-1:0] vel_x_reg, vel_x_next;
    logic signed [SPEED_W-1:0] vel_y_reg, vel_y_next;
    logic                      axis_sel_reg, axis_sel_next;
    logic                      flag_reg, flag_next;

    // result stage
    logic                      out_valid_reg;
    logic [POS_W-1:0]          cursor_x_reg;
    logic [POS_W-1:0]          cursor_y_reg;
    logic signed [SPEED_W-1:0] speed_x_reg;
    logic signed [SPEED_W-1:0] speed_y_reg;
    logic                      motion_reg;
    logic                      axis_out_reg;

    // datapath
    logic [SAMPLE_W-1:0]       center;
    logic signed [SPEED_W-1:0] offset;
    logic                      off_neg;
    logic [SAMPLE_W-1:0]       mag;
    logic                      in_dead;
    logic [SAMPLE_W-1:0]       adj_mag;
    logic [STEP_W-1:0]         step_mag;
    logic signed [POS_W+1:0]   step;
    logic [POS_W-1:0]          pos_cur;
    logic [POS_W-1:0]          limit;
    logic signed [POS_W+1:0]   pos_sum;
    logic [POS_W-1:0]          pos_clamped;
    logic signed [SPEED_W-1:0] vel_new;

    // handshake
    logic out_load;
    logic s1_load;

    assign out_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load   = in_valid && !in_stall;
    assign in_stall  = s1_valid_reg && !out_load;
    assign cfg_ready = 1'b1;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_x_reg    <= REST_X_RST;
            rest_y_reg    <= REST_Y_RST;
            dead_zone_reg <= DEAD_ZONE_RST;
            limit_x_reg   <= LIMIT_X_RST;
            limit_y_reg   <= LIMIT_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_REST_X:    rest_x_reg    <= cfg_data;
                REG_REST_Y:    rest_y_reg    <= cfg_data;
                REG_DEAD_ZONE: dead_zone_reg <= cfg_data;
                REG_LIMIT_X:   limit_x_reg   <= cfg_data;
                REG_LIMIT_Y:   limit_y_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg     <= op_t'(opcode);
            s1_sample_reg <= sample;
        end
    end

    // offset from center and dead zone, worked on the magnitude
    always_comb
    begin
        center  = (axis_sel_reg == AXIS_Y) ? rest_y_reg : rest_x_reg;
        offset  = $signed({1'b0, s1_sample_reg}) - $signed({1'b0, center});
        off_neg = offset[SPEED_W-1];
        mag     = off_neg ? SAMPLE_W'(-offset) : SAMPLE_W'(offset);
        in_dead = (mag < dead_zone_reg);
        adj_mag = in_dead ? '0 : (mag - dead_zone_reg);
        // truncation toward zero: shift the magnitude, then restore the sign
        step_mag = adj_mag[SAMPLE_W-1:STEP_SHIFT];
        step     = off_neg ? -$signed({2'b00, {(POS_W-STEP_W){1'b0}}, step_mag})
                           :  $signed({2'b00, {(POS_W-STEP_W){1'b0}}, step_mag});
        // velocity is the negated shrunk offset
        vel_new  = off_neg ? $signed({1'b0, adj_mag}) : -$signed({1'b0, adj_mag});
    end

    // position update and clamp to 0..limit
    always_comb
    begin
        pos_cur = (axis_sel_reg == AXIS_Y) ? pos_y_reg : pos_x_reg;
        limit   = (axis_sel_reg == AXIS_Y) ? limit_y_reg : limit_x_reg;
        pos_sum = $signed({2'b00, pos_cur}) + step;
        if (pos_sum < 0)
        begin
            pos_clamped = '0;
        end
        else if (pos_sum > $signed({2'b00, limit}))
        begin
            pos_clamped = limit;
        end
        else
        begin
            pos_clamped = pos_sum[POS_W-1:0];
        end
    end

    // next cursor state
    always_comb
    begin
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        vel_x_next    = vel_x_reg;
        vel_y_next    = vel_y_reg;
        axis_sel_next = axis_sel_reg;
        flag_next     = flag_reg;
        case (s1_op_reg)
            OP_READ:
            begin
                flag_next = 1'b0;
            end
            OP_SAMPLE:
            begin
                if (!in_dead)
                begin
                    flag_next = 1'b1;
                end
                if (axis_sel_reg == AXIS_Y)
                begin
                    pos_y_next = pos_clamped;
                    vel_y_next = vel_new;
                end
                else
                begin
                    pos_x_next = pos_clamped;
                    vel_x_next = vel_new;
                end
                axis_sel_next = !axis_sel_reg;
            end
            default:
            begin
                flag_next = flag_reg;
            end
        endcase
    end

    // cursor state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            vel_x_reg    <= '0;
            vel_y_reg    <= '0;
            axis_sel_reg <= AXIS_X;
            flag_reg     <= 1'b0;
        end
        else if (out_load)
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            vel_x_reg    <= vel_x_next;
            vel_y_reg    <= vel_y_next;
            axis_sel_reg <= axis_sel_next;
            flag_reg     <= flag_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cursor_x_reg <= pos_x_next;
            cursor_y_reg <= pos_y_next;
            speed_x_reg  <= vel_x_next;
            speed_y_reg  <= vel_y_next;
            motion_reg   <= flag_next;
            axis_out_reg <= axis_sel_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_x       = cursor_x_reg;
    assign cursor_y       = cursor_y_reg;
    assign speed_x        = speed_x_reg;
    assign speed_y        = speed_y_reg;
    assign motion_pending = motion_reg;
    assign next_axis      = axis_out_reg;

    // stall toward the source only with a held item in the input stage
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input stage");

    // every processed item shows up as a result
    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("processed item produced no result");

    // a sample flips the axis, a read keeps it
    a_sample_flips_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s1_op_reg == OP_SAMPLE) |=> (axis_sel_reg != $past(axis_sel_reg)))
        else $error("sample did not switch axis");

    a_read_keeps_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s1_op_reg == OP_READ) |=> (axis_sel_reg == $past(axis_sel_reg))
            && !flag_reg)
        else $error("read changed axis or left the motion flag set");

    // the shrunk offset never reaches the most negative code
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (speed_x_reg != 11'sh400) && (speed_y_reg != 11'sh400))
        else $error("velocity out of range");

endmodule
